// ===== hw/rtl/two_tape_instruction_executor_defines.svh =====
// Assertion macros for the two-tape instruction executor.
// Included by RTL files that carry concurrent assertions; no dependencies.
`ifndef TWO_TAPE_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define TWO_TAPE_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTIE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TTIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ttie_pkg.sv =====
// Package for the two-tape instruction executor: field types, opcodes,
// result kinds and default tape depths. No dependencies.
`default_nettype none

package ttie_pkg;

	typedef logic [7:0]  instr_t;
	typedef logic [15:0] word_t;
	typedef logic [2:0]  kind_t;
	typedef logic [1:0]  step_t;

	localparam int TOP_DEPTH_DEF    = 128;
	localparam int BOTTOM_DEPTH_DEF = 16384;

	localparam instr_t OP_KEY    = 8'h2C; // ','
	localparam instr_t OP_ZERO   = 8'h21; // '!'
	localparam instr_t OP_ADD50  = 8'h25; // '%'
	localparam instr_t OP_ADD5   = 8'h2A; // '*'
	localparam instr_t OP_INC    = 8'h2B; // '+'
	localparam instr_t OP_DEC    = 8'h2D; // '-'
	localparam instr_t OP_OUT    = 8'h2E; // '.'
	localparam instr_t OP_BRIGHT = 8'h3E; // '>'
	localparam instr_t OP_BLEFT  = 8'h3C; // '<'
	localparam instr_t OP_TRIGHT = 8'h64; // 'd'
	localparam instr_t OP_TLEFT  = 8'h61; // 'a'
	localparam instr_t OP_UP     = 8'h5E; // '^'
	localparam instr_t OP_DOWN   = 8'h76; // 'v'
	localparam instr_t OP_JMP    = 8'h24; // '$'
	localparam instr_t OP_JEQ    = 8'h3F; // '?'

	localparam kind_t KIND_NONE     = 3'd0;
	localparam kind_t KIND_PIXEL    = 3'd1;
	localparam kind_t KIND_COLOUR   = 3'd2;
	localparam kind_t KIND_JUMP     = 3'd3;
	localparam kind_t KIND_BAD_JUMP = 3'd4;

	localparam word_t ADD_BIG   = 16'd50;
	localparam word_t ADD_SMALL = 16'd5;

	localparam step_t STEP_ONE   = 2'd0;
	localparam step_t STEP_JEQ   = 2'd2;
	localparam step_t STEP_OUT   = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/two_tape_instruction_executor.sv =====
// Result: result_valid and the result fields are registered when an instruction completes.
// Throughput: one instruction per cycle while the result slot is free, except '?' and
// '.', which are held by the single read port of the top-tape memory (one word per cycle).
// Reset: pointers zero; a clearing pass over all max(TOP_DEPTH, BOTTOM_DEPTH) addresses
// (16384 by default) zeroes both tapes while instr_ready stays low.
// Two-tape instruction executor top level; uses ttie_pkg and the defines header.
`default_nettype none
`include "two_tape_instruction_executor_defines.svh"

module two_tape_instruction_executor #(
	parameter int TOP_DEPTH    = ttie_pkg::TOP_DEPTH_DEF,
	parameter int BOTTOM_DEPTH = ttie_pkg::BOTTOM_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                instr_valid,
	output logic               instr_ready,
	input  ttie_pkg::instr_t   instruction,
	input  ttie_pkg::word_t    key_value,
	output logic               result_valid,
	input  wire                result_ready,
	output ttie_pkg::kind_t    out_kind,
	output ttie_pkg::word_t    arg_first,
	output ttie_pkg::word_t    arg_second,
	output ttie_pkg::word_t    arg_third,
	output ttie_pkg::word_t    label_number
);
	import ttie_pkg::*;

	localparam int TAW  = $clog2(TOP_DEPTH);
	localparam int BAW  = $clog2(BOTTOM_DEPTH);
	localparam int MAXD = (TOP_DEPTH > BOTTOM_DEPTH) ? TOP_DEPTH : BOTTOM_DEPTH;
	localparam int CW   = $clog2(MAXD);

	// tapes
	word_t top_mem [TOP_DEPTH];
	word_t bot_mem [BOTTOM_DEPTH];

	logic [CW-1:0]  clr_cnt_q;
	logic           clr_done_q;

	logic [TAW-1:0] tp_q;
	logic [BAW-1:0] bp_q;

	logic           v_s1;
	step_t          step_s1;
	instr_t         op_s1;
	word_t          key_s1;
	logic [TAW-1:0] tp_s1;
	logic [BAW-1:0] bp_s1;

	word_t          t0_q, t1_q, t2_q;

	word_t          top_mem_q, bot_mem_q;
	logic           top_fwd_q, bot_fwd_q;
	word_t          top_fwd_d_q, bot_fwd_d_q;
	word_t          top_rdata, bot_rdata;

	logic           accept, advance, done, out_free;
	step_t          last_step;

	logic           top_we, top_re, bot_we, bot_re;
	logic [TAW-1:0] top_waddr, top_raddr;
	logic [BAW-1:0] bot_waddr, bot_raddr;
	word_t          top_wdata, bot_wdata;
	logic [TAW:0]   top_sum;
	logic           clr_top_hit, clr_bot_hit;

	kind_t          res_kind;
	word_t          res_a1, res_a2, res_a3, res_lab, t0;

	assign top_rdata = top_fwd_q ? top_fwd_d_q : top_mem_q;
	assign bot_rdata = bot_fwd_q ? bot_fwd_d_q : bot_mem_q;

	always_comb begin
		case (op_s1)
			OP_OUT:  last_step = STEP_OUT;
			OP_JEQ:  last_step = STEP_JEQ;
			default: last_step = STEP_ONE;
		endcase
	end

	assign out_free    = !result_valid || result_ready;
	assign done        = v_s1 && (step_s1 == last_step) && out_free;
	assign advance     = v_s1 && (step_s1 != last_step);
	assign instr_ready = clr_done_q && (!v_s1 || done);
	assign accept      = instr_valid && instr_ready;

	// clearing pass
	assign clr_top_hit = !clr_done_q && ({1'b0, clr_cnt_q} < (CW + 1)'(TOP_DEPTH));
	assign clr_bot_hit = !clr_done_q && ({1'b0, clr_cnt_q} < (CW + 1)'(BOTTOM_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			if (clr_cnt_q == CW'(MAXD - 1)) begin
				clr_done_q <= 1'b1;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// top-tape read address: offset 0 on accept, then offsets 1..3
	always_comb begin
		top_sum = {1'b0, tp_s1} + (TAW + 1)'(step_s1) + (TAW + 1)'(1);
		if (top_sum >= (TAW + 1)'(TOP_DEPTH)) begin
			top_sum = top_sum - (TAW + 1)'(TOP_DEPTH);
		end
		top_re    = accept || advance;
		top_raddr = accept ? tp_q : top_sum[TAW-1:0];
		bot_re    = accept;
		bot_raddr = bp_q;
	end

	always_comb begin
		if (!clr_done_q) begin
			top_we    = clr_top_hit;
			top_waddr = clr_cnt_q[TAW-1:0];
			top_wdata = '0;
		end else begin
			top_we    = done && (op_s1 == OP_UP);
			top_waddr = tp_s1;
			top_wdata = bot_rdata;
		end
	end

	always_comb begin
		bot_wdata = '0;
		case (op_s1)
			OP_KEY:   bot_wdata = key_s1;
			OP_ADD50: bot_wdata = bot_rdata + ADD_BIG;
			OP_ADD5:  bot_wdata = bot_rdata + ADD_SMALL;
			OP_INC:   bot_wdata = bot_rdata + 16'd1;
			OP_DEC:   bot_wdata = bot_rdata - 16'd1;
			OP_DOWN:  bot_wdata = top_rdata;
			default:  bot_wdata = '0;
		endcase
		if (!clr_done_q) begin
			bot_we    = clr_bot_hit;
			bot_waddr = clr_cnt_q[BAW-1:0];
			bot_wdata = '0;
		end else begin
			bot_we    = done && (op_s1 inside {OP_KEY, OP_ZERO, OP_ADD50, OP_ADD5,
				OP_INC, OP_DEC, OP_DOWN});
			bot_waddr = bp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (top_we) begin
			top_mem[top_waddr] <= top_wdata;
		end
		if (top_re) begin
			top_mem_q <= top_mem[top_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (bot_we) begin
			bot_mem[bot_waddr] <= bot_wdata;
		end
		if (bot_re) begin
			bot_mem_q <= bot_mem[bot_raddr];
		end
	end

	// write-to-read forwarding on same-edge hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_fwd_q <= 1'b0;
			bot_fwd_q <= 1'b0;
		end else begin
			if (top_re) begin
				top_fwd_q <= top_we && (top_waddr == top_raddr);
			end
			if (bot_re) begin
				bot_fwd_q <= bot_we && (bot_waddr == bot_raddr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (top_re) begin
			top_fwd_d_q <= top_wdata;
		end
		if (bot_re) begin
			bot_fwd_d_q <= bot_wdata;
		end
	end

	// pointers and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q    <= '0;
			bp_q    <= '0;
			v_s1    <= 1'b0;
			step_s1 <= STEP_ONE;
		end else begin
			if (accept) begin
				v_s1    <= 1'b1;
				step_s1 <= STEP_ONE;
				case (instruction)
					OP_BRIGHT: bp_q <= (bp_q == BAW'(BOTTOM_DEPTH - 1)) ? '0 : bp_q + 1'b1;
					OP_BLEFT:  bp_q <= (bp_q == '0) ? BAW'(BOTTOM_DEPTH - 1) : bp_q - 1'b1;
					OP_TRIGHT: tp_q <= (tp_q == TAW'(TOP_DEPTH - 1)) ? '0 : tp_q + 1'b1;
					OP_TLEFT:  tp_q <= (tp_q == '0) ? TAW'(TOP_DEPTH - 1) : tp_q - 1'b1;
					default: begin
					end
				endcase
			end else if (done) begin
				v_s1 <= 1'b0;
			end else if (advance) begin
				step_s1 <= step_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= instruction;
			key_s1 <= key_value;
			tp_s1  <= tp_q;
			bp_s1  <= bp_q;
		end
		if (advance) begin
			case (step_s1)
				2'd0:    t0_q <= top_rdata;
				2'd1:    t1_q <= top_rdata;
				default: t2_q <= top_rdata;
			endcase
		end
	end

	// result
	assign t0 = (step_s1 == STEP_ONE) ? top_rdata : t0_q;

	always_comb begin
		res_kind = KIND_NONE;
		res_a1   = '0;
		res_a2   = '0;
		res_a3   = '0;
		res_lab  = '0;
		case (op_s1)
			OP_OUT: begin
				if (t0 == 16'd0) begin
					res_kind = KIND_PIXEL;
					res_a1   = t1_q;
					res_a2   = t2_q;
				end else if (t0 == 16'd1) begin
					res_kind = KIND_COLOUR;
					res_a1   = t1_q;
					res_a2   = t2_q;
					res_a3   = top_rdata;
				end
			end
			OP_JMP, OP_JEQ: begin
				if ((op_s1 == OP_JMP) || (t1_q == top_rdata)) begin
					if (t0 == 16'd0) begin
						res_kind = KIND_BAD_JUMP;
					end else begin
						res_kind = KIND_JUMP;
						res_lab  = t0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (done) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_kind     <= res_kind;
			arg_first    <= res_a1;
			arg_second   <= res_a2;
			arg_third    <= res_a3;
			label_number <= res_lab;
		end
	end

	`TTIE_ASSERT_NEXT(a_done_loads_result, clk, arst_n, done, result_valid)
	`TTIE_ASSERT_NEXT(a_step_advances, clk, arst_n, advance,
		v_s1 && (step_s1 == $past(step_s1) + 2'd1))
	`TTIE_ASSERT_SAME(a_idle_while_clearing, clk, arst_n, !clr_done_q, !v_s1)
	`TTIE_ASSERT_SAME(a_bad_jump_no_label, clk, arst_n,
		result_valid && (out_kind == KIND_BAD_JUMP), label_number == 16'd0)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for two_tape_instruction_executor: directed rows, then random
// instruction sequences, scored against an in-bench tape predictor or typed-in expectations.
// Depends on ttie_pkg and the executor RTL.
`default_nettype none

module tb;
	import ttie_pkg::*;

	localparam int TOP_N        = TOP_DEPTH_DEF;
	localparam int BOT_N        = BOTTOM_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1025;
	localparam int IDLE_LIMIT   = 60000;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 20;

	localparam instr_t INSTR_HASH     = 8'h23;
	localparam instr_t INSTR_ALL_ONES = 8'hFF;

	localparam instr_t ALL_OPS [15] = '{OP_KEY, OP_ZERO, OP_ADD50, OP_ADD5, OP_INC, OP_DEC,
		OP_OUT, OP_BRIGHT, OP_BLEFT, OP_TRIGHT, OP_TLEFT, OP_UP, OP_DOWN, OP_JMP, OP_JEQ};
	localparam instr_t CELL_OPS [9] = '{OP_KEY, OP_ZERO, OP_ADD50, OP_ADD5, OP_INC, OP_DEC,
		OP_UP, OP_DOWN, OP_OUT};
	localparam instr_t MOVE_OPS [4] = '{OP_BRIGHT, OP_BLEFT, OP_TRIGHT, OP_TLEFT};

	typedef struct packed {
		kind_t kind;
		word_t first;
		word_t second;
		word_t third;
		word_t label;
	} exec_result_t;

	typedef struct packed {
		instr_t       op;
		word_t        key;
		logic         known;
		exec_result_t want;
	} instr_item_t;

	logic   clk;
	logic   arst_n;
	logic   instr_valid;
	logic   instr_ready;
	instr_t instruction;
	word_t  key_value;
	logic   result_valid;
	logic   result_ready;
	kind_t  out_kind;
	word_t  arg_first;
	word_t  arg_second;
	word_t  arg_third;
	word_t  label_number;

	word_t top_cells [TOP_N];
	word_t bottom_cells [BOT_N];
	int    top_ptr;
	int    bot_ptr;

	exec_result_t pending_results [$];
	instr_item_t  program_q [$];
	int           mismatches;
	int           checked;
	int           sent;
	int           kind_seen [8];
	bit           no_idle;
	bit           held_off;

	two_tape_instruction_executor #(
		.TOP_DEPTH(TOP_N),
		.BOTTOM_DEPTH(BOT_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_ready(instr_ready),
		.instruction(instruction),
		.key_value(key_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_kind(out_kind),
		.arg_first(arg_first),
		.arg_second(arg_second),
		.arg_third(arg_third),
		.label_number(label_number)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic word_t top_word(int off);
		return top_cells[(top_ptr + off) % TOP_N];
	endfunction

	function automatic exec_result_t execute_instruction(instr_t op, word_t key);
		exec_result_t r;
		word_t head;
		r = '0;
		head = top_cells[top_ptr];
		case (op)
			OP_KEY:    bottom_cells[bot_ptr] = key;
			OP_ZERO:   bottom_cells[bot_ptr] = '0;
			OP_ADD50:  bottom_cells[bot_ptr] = bottom_cells[bot_ptr] + ADD_BIG;
			OP_ADD5:   bottom_cells[bot_ptr] = bottom_cells[bot_ptr] + ADD_SMALL;
			OP_INC:    bottom_cells[bot_ptr] = bottom_cells[bot_ptr] + 16'd1;
			OP_DEC:    bottom_cells[bot_ptr] = bottom_cells[bot_ptr] - 16'd1;
			OP_OUT: begin
				if (head == 16'd0) begin
					r.kind = KIND_PIXEL;
					r.first = top_word(1);
					r.second = top_word(2);
				end else if (head == 16'd1) begin
					r.kind = KIND_COLOUR;
					r.first = top_word(1);
					r.second = top_word(2);
					r.third = top_word(3);
				end
			end
			OP_BRIGHT: bot_ptr = (bot_ptr + 1) % BOT_N;
			OP_BLEFT:  bot_ptr = (bot_ptr + BOT_N - 1) % BOT_N;
			OP_TRIGHT: top_ptr = (top_ptr + 1) % TOP_N;
			OP_TLEFT:  top_ptr = (top_ptr + TOP_N - 1) % TOP_N;
			OP_UP:     top_cells[top_ptr] = bottom_cells[bot_ptr];
			OP_DOWN:   bottom_cells[bot_ptr] = head;
			OP_JMP, OP_JEQ: begin
				if (op == OP_JMP || top_word(1) == top_word(2)) begin
					if (head == 16'd0) begin
						r.kind = KIND_BAD_JUMP;
					end else begin
						r.kind = KIND_JUMP;
						r.label = head;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic word_t any_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic int idle_cycles();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_op(instr_t op, word_t key);
		instr_item_t it;
		it = '0;
		it.op = op;
		it.key = key;
		program_q.push_back(it);
	endtask

	task automatic push_known(instr_t op, word_t key, kind_t kind, word_t a, word_t b,
			word_t c, word_t l);
		instr_item_t it;
		it.op = op;
		it.key = key;
		it.known = 1'b1;
		it.want = '{kind, a, b, c, l};
		program_q.push_back(it);
	endtask

	// Well-formed draw and jump sequences dominate; the rest is cell churn, pointer moves and noise.
	task automatic queue_random_block();
		word_t v;
		int    r;
		int    n;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			n = $urandom_range(0, 9);
			v = (n < 5) ? 16'd0 : (n < 9) ? 16'd1 : any_word();
			push_op(OP_KEY, v);
			push_op(OP_UP, any_word());
			repeat (3) begin
				push_op(OP_TRIGHT, any_word());
				push_op(OP_KEY, any_word());
				push_op(OP_UP, any_word());
			end
			repeat (3) push_op(OP_TLEFT, any_word());
			push_op(OP_OUT, any_word());
		end else if (r < 60) begin
			push_op(OP_KEY, ($urandom_range(0, 5) == 0) ? 16'd0 : any_word());
			push_op(OP_UP, any_word());
			if ($urandom_range(0, 2) == 0) begin
				push_op(OP_JMP, any_word());
			end else begin
				v = any_word();
				push_op(OP_TRIGHT, any_word());
				push_op(OP_KEY, v);
				push_op(OP_UP, any_word());
				push_op(OP_TRIGHT, any_word());
				push_op(OP_KEY, ($urandom_range(0, 2) != 0) ? v : any_word());
				push_op(OP_UP, any_word());
				push_op(OP_TLEFT, any_word());
				push_op(OP_TLEFT, any_word());
				push_op(OP_JEQ, any_word());
			end
		end else if (r < 75) begin
			repeat ($urandom_range(2, 8))
				push_op(CELL_OPS[$urandom_range(0, 8)], any_word());
		end else if (r < 85) begin
			v = word_t'(MOVE_OPS[$urandom_range(0, 3)]);
			repeat ($urandom_range(1, 10)) push_op(instr_t'(v), any_word());
		end else begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 2) == 0)
					push_op(instr_t'($urandom), word_t'($urandom));
				else
					push_op(ALL_OPS[$urandom_range(0, 14)], any_word());
			end
		end
	endtask

	task automatic send_item(instr_item_t it);
		int gap;
		exec_result_t got;
		gap = idle_cycles();
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_valid <= 1'b1;
		instruction <= it.op;
		key_value <= it.key;
		@(posedge clk);
		while (!instr_ready) @(posedge clk);
		got = execute_instruction(it.op, it.key);
		pending_results.push_back(it.known ? it.want : got);
		sent++;
		@(negedge clk);
	endtask

	task automatic check_field(string name, word_t want, word_t got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		exec_result_t want;
		if (arst_n && result_valid && result_ready) begin
			kind_seen[out_kind]++;
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected, out_kind %0d", out_kind);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_kind", word_t'(want.kind), word_t'(out_kind));
				check_field("arg_first", want.first, arg_first);
				check_field("arg_second", want.second, arg_second);
				check_field("arg_third", want.third, arg_third);
				check_field("label_number", want.label, label_number);
			end
			checked++;
		end
	end

	initial begin : result_sink
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = idle_cycles();
			if (!held_off && checked >= HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				held_off = 1'b1;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((instr_valid && instr_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : main_flow
		int idx;
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instruction = '0;
		key_value = '0;
		mismatches = 0;
		checked = 0;
		sent = 0;
		no_idle = 1'b0;
		held_off = 1'b0;
		top_ptr = 0;
		bot_ptr = 0;
		foreach (kind_seen[k]) kind_seen[k] = 0;
		foreach (top_cells[k]) top_cells[k] = '0;
		foreach (bottom_cells[k]) bottom_cells[k] = '0;

		// directed rows; expectations typed in only for the fresh-reset and no-output cases
		push_known(OP_OUT, 16'h0000, KIND_PIXEL, 0, 0, 0, 0);
		push_known(OP_JMP, 16'h0000, KIND_BAD_JUMP, 0, 0, 0, 0);
		push_known(OP_JEQ, 16'h0000, KIND_BAD_JUMP, 0, 0, 0, 0);
		push_known(INSTR_HASH, 16'hFFFF, KIND_NONE, 0, 0, 0, 0);
		push_known(INSTR_ALL_ONES, 16'hFFFF, KIND_NONE, 0, 0, 0, 0);
		push_known(OP_KEY, 16'hFFFF, KIND_NONE, 0, 0, 0, 0);
		push_known(OP_INC, 16'h0000, KIND_NONE, 0, 0, 0, 0);
		push_op(OP_DEC, 16'h0000);
		push_op(OP_ADD50, 16'h0000);
		push_op(OP_ADD5, 16'h0000);
		push_op(OP_UP, 16'h0000);
		push_op(OP_OUT, 16'h0000);
		push_op(OP_JMP, 16'h0000);
		push_op(OP_ZERO, 16'hFFFF);
		push_op(OP_BLEFT, 16'h0000);
		push_op(OP_KEY, 16'h0001);
		push_op(OP_TLEFT, 16'h0000);
		push_op(OP_UP, 16'h0000);
		push_op(OP_BRIGHT, 16'h0000);
		push_op(OP_KEY, 16'hA5A5);
		push_op(OP_TRIGHT, 16'h0000);
		push_op(OP_TLEFT, 16'h0000);
		push_op(OP_OUT, 16'h5A5A);
		push_op(OP_DOWN, 16'h0000);
		push_op(OP_JEQ, 16'h0000);

		idx = program_q.size();
		while (program_q.size() < idx + RANDOM_ITEMS) queue_random_block();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idx = 0;
		foreach (program_q[i]) begin
			no_idle = (idx >= 400 && idx < 520);
			send_item(program_q[i]);
			idx++;
		end
		instr_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d instructions, %0d results compared, %0d mismatches",
			sent, checked, mismatches);
		$display("run: pixel %0d, colour %0d, jump %0d, bad jump %0d, none %0d",
			kind_seen[KIND_PIXEL], kind_seen[KIND_COLOUR], kind_seen[KIND_JUMP],
			kind_seen[KIND_BAD_JUMP], kind_seen[KIND_NONE]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
